// ----- hw/rtl/tedet_pkg.sv -----
// ----------------------------------------------------------------------------
// tedet_pkg
// Shared types and constants for the text encoding detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tedet_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    localparam logic [2:0] REQ_AUTO   = 3'd0;
    localparam logic [2:0] REQ_UTF8   = 3'd1;
    localparam logic [2:0] REQ_ASCII  = 3'd2;
    localparam logic [2:0] REQ_LATIN1 = 3'd3;
    localparam logic [2:0] REQ_CP437  = 3'd4;

    localparam logic [1:0] ENC_UTF8   = 2'd0;
    localparam logic [1:0] ENC_ASCII  = 2'd1;
    localparam logic [1:0] ENC_LATIN1 = 2'd2;
    localparam logic [1:0] ENC_CP437  = 2'd3;

    localparam logic REG_REQ_ENC = 1'b0;
    localparam logic REG_ART     = 1'b1;

    typedef enum logic [2:0] {
        RULE_NONE  = 3'd0,
        RULE_A0_BF = 3'd1,
        RULE_80_9F = 3'd2,
        RULE_90_BF = 3'd3,
        RULE_80_8F = 3'd4
    } rule_t;

    typedef struct packed {
        logic [1:0] prefix_count;
        logic       bom_matching;
        logic       still_valid;
        logic [1:0] cont_left;
        rule_t      rule;
    } scan_state_t;

    typedef struct packed {
        logic [1:0] resolved_encoding;
        logic       had_bom;
        logic       utf8_valid;
    } result_t;

    localparam scan_state_t SCAN_CLEAR = '{
        prefix_count: 2'd0,
        bom_matching: 1'b1,
        still_valid:  1'b1,
        cont_left:    2'd0,
        rule:         RULE_NONE
    };

    function automatic logic [7:0] bom_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0: val = 8'hEF;
            2'd1: val = 8'hBB;
            2'd2: val = 8'hBF;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tedet_step.sv -----
// ----------------------------------------------------------------------------
// tedet_step
// Per-byte scan update (BOM prefix and strict UTF-8) and end-of-buffer
// encoding resolution.
// ----------------------------------------------------------------------------
`default_nettype none

module tedet_step (
    input  wire tedet_pkg::scan_state_t cur,
    input  wire logic [7:0]             byte_value,
    input  wire logic                   take,
    input  wire logic [2:0]             requested_encoding,
    input  wire logic                   art_file_type,
    output tedet_pkg::scan_state_t      nxt,
    output tedet_pkg::result_t          res
);
    import tedet_pkg::*;

    scan_state_t st;
    logic        allows;
    logic        bom;
    logic        valid;

    always_comb
    begin
        unique case (cur.rule)
            RULE_A0_BF: allows = byte_value >= 8'hA0;
            RULE_80_9F: allows = byte_value <= 8'h9F;
            RULE_90_BF: allows = byte_value >= 8'h90;
            RULE_80_8F: allows = byte_value <= 8'h8F;
            default:    allows = 1'b1;
        endcase
    end

    always_comb
    begin
        st = cur;
        if (take)
        begin
            if (cur.prefix_count != 2'd3)
            begin
                if (byte_value != bom_byte(cur.prefix_count))
                    st.bom_matching = 1'b0;
                st.prefix_count = cur.prefix_count + 2'd1;
            end
            if (cur.still_valid)
            begin
                if (cur.cont_left != 2'd0)
                begin
                    if (byte_value[7:6] != 2'b10 || !allows)
                    begin
                        st.still_valid = 1'b0;
                        st.cont_left   = 2'd0;
                    end
                    else
                        st.cont_left = cur.cont_left - 2'd1;
                    st.rule = RULE_NONE;
                end
                else if (byte_value < 8'h80)
                begin
                end
                else if (byte_value >= 8'hC2 && byte_value <= 8'hDF)
                    st.cont_left = 2'd1;
                else if (byte_value[7:4] == 4'hE)
                begin
                    st.cont_left = 2'd2;
                    st.rule = (byte_value == 8'hE0) ? RULE_A0_BF :
                              (byte_value == 8'hED) ? RULE_80_9F : RULE_NONE;
                end
                else if (byte_value >= 8'hF0 && byte_value <= 8'hF4)
                begin
                    st.cont_left = 2'd3;
                    st.rule = (byte_value == 8'hF0) ? RULE_90_BF :
                              (byte_value == 8'hF4) ? RULE_80_8F : RULE_NONE;
                end
                else
                    st.still_valid = 1'b0;
            end
        end
    end

    assign nxt   = st;
    assign bom   = (st.prefix_count == 2'd3) && st.bom_matching;
    assign valid = st.still_valid && (st.cont_left == 2'd0);

    always_comb
    begin
        res.utf8_valid = valid;
        res.had_bom    = 1'b0;
        unique case (requested_encoding)
            REQ_UTF8:
            begin
                res.resolved_encoding = ENC_UTF8;
                res.had_bom           = bom;
            end
            REQ_ASCII:  res.resolved_encoding = ENC_ASCII;
            REQ_LATIN1: res.resolved_encoding = ENC_LATIN1;
            REQ_CP437:  res.resolved_encoding = ENC_CP437;
            default:
            begin
                res.had_bom = bom;
                if (bom || valid)
                    res.resolved_encoding = ENC_UTF8;
                else
                    res.resolved_encoding = art_file_type ? ENC_CP437 : ENC_ASCII;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/text_encoding_detector_core.sv -----
// ----------------------------------------------------------------------------
// text_encoding_detector_core
// Streams a buffer's bytes, checks for the UTF-8 BOM and strict UTF-8, and
// reports the resolved encoding when the buffer ends.
//
// Input channel s_axis: one byte per item, tlast on the final byte, tuser
// set for a no-data item (empty buffer; it also ends the buffer).
// Output channel m_axis: one item per buffer, issued for the ending item.
// Configuration over APB: 0x0 requested encoding, 0x4 art file type; write
// only while the block is idle.
// Throughput is one byte per cycle, set by the combinational scan update
// between the input register and the state/result registers. The result is
// registered: an ending item passes the input register, then the result register.
// When m_axis stalls, non-ending bytes keep flowing; an ending item waits in
// the input register until the result register frees up.
// Reset clears the configuration registers, the scan state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module text_encoding_detector_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [tedet_pkg::DATA_W-1:0] s_axis_tdata,  // [7:0] byte_value
    input  wire logic                         s_axis_tlast,
    input  wire logic                         s_axis_tuser,  // [0] no_data
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [1:0] resolved_encoding, [2] had_bom, [3] utf8_valid, [7:4] zero
    output logic [tedet_pkg::DATA_W-1:0]      m_axis_tdata,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tedet_pkg::APB_AW-1:0] paddr,
    input  wire logic [tedet_pkg::APB_DW-1:0] pwdata,
    output logic [tedet_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);
    import tedet_pkg::*;

    logic [2:0]  req_enc_reg;
    logic        art_reg;
    logic        cfg_wr;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        in_none_reg;
    logic        in_end;
    logic        in_adv;

    scan_state_t state_reg;
    scan_state_t state_next;
    result_t     res;

    logic        out_valid_reg;
    result_t     out_data_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_enc_reg <= REQ_AUTO;
            art_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_REQ_ENC: req_enc_reg <= pwdata[2:0];
                REG_ART:     art_reg     <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_REQ_ENC: prdata[2:0] = req_enc_reg;
            REG_ART:     prdata[0]   = art_reg;
            default:     ;
        endcase
    end

    assign in_end        = in_last_reg || in_none_reg;
    assign in_adv        = in_valid_reg && (!in_end || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
            in_none_reg <= s_axis_tuser;
        end
    end

    tedet_step u_step (
        .cur                (state_reg),
        .byte_value         (in_byte_reg),
        .take               (!in_none_reg),
        .requested_encoding (req_enc_reg),
        .art_file_type      (art_reg),
        .nxt                (state_next),
        .res                (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SCAN_CLEAR;
        else if (in_adv)
            state_reg <= in_end ? SCAN_CLEAR : state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_adv && in_end)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_end)
            out_data_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_data_reg.utf8_valid, out_data_reg.had_bom,
                            out_data_reg.resolved_encoding};

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_adv && in_end |=> m_axis_tvalid)
        else $error("ending item did not load the result register");

    a_bom_means_utf8: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == ENC_UTF8)
        else $error("BOM reported with a non-UTF-8 encoding");

    a_owed_only_if_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cont_left != 2'd0 |-> state_reg.still_valid)
        else $error("continuation bytes owed after an error");

    a_rule_needs_owed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.rule != RULE_NONE |-> state_reg.cont_left != 2'd0)
        else $error("second-byte rule pending with no continuation owed");

endmodule

`default_nettype wire
